### sv/ssbc_pkg.sv
`timescale 1ns / 1ps
// shared constants for the samplesort bucket classifier
// no dependencies; imported by the top level and its checker
package ssbc_pkg;

  localparam int KEY_FIELD_W     = 32;
  localparam int BUCKET_W        = 3;
  localparam int SLOT_W          = 17;
  localparam int BUCKET_COUNT_W  = 4;
  localparam int SPLITTER_W      = 32;
  localparam int SPLITTER_REGS   = 7;
  localparam int CFG_INDEX_W     = 4;
  localparam int CFG_DATA_W      = 32;
  localparam int S_TDATA_W       = 32;
  localparam int M_TDATA_W       = 24;
  localparam int RESULT_W        = BUCKET_W + SLOT_W + 1;

  localparam int KEY_WIDTH_DEF   = 32;
  localparam int MAX_BUCKETS_DEF = 8;
  localparam int MAX_ITEMS_DEF   = 65536;

  localparam logic [BUCKET_COUNT_W-1:0] BUCKET_COUNT_RESET = 4'd8;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_COUNT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPLITTER_0   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPLITTER_6   = 4'd7;

endpackage

### sv/sample_sort_bucket_classifier.sv
`timescale 1ns / 1ps
// samplesort bucket classifier: bucket index, per-bucket slot and sorted tracking
// depends on ssbc_pkg
//
//  channel  dir  payload (lowest bits first)                      accepted when
//  s_*      in   tdata: key[31:0]; tuser: first                    s_tvalid & s_tready
//  m_*      out  tdata: bucket[2:0], slot[19:3], sorted[20], 0s    m_tvalid & m_tready
//  cfg_*    in   index 0 bucket_count, 1..7 splitter_0..6          cfg_we
//
// one item per cycle sustained while the output is not stalled; a request lands in the input
// register when accepted and its result in the result register when the input stage advances,
// bucket compare and tally update in between.
// rst clears both stage valids, the tallies, the sorted tracking and the configuration registers.
// a stalled output holds its result; input keeps flowing while the input stage
// can hand its item to the result register.
module sample_sort_bucket_classifier #(
  parameter int KEY_WIDTH   = ssbc_pkg::KEY_WIDTH_DEF,
  parameter int MAX_BUCKETS = ssbc_pkg::MAX_BUCKETS_DEF,
  parameter int MAX_ITEMS   = ssbc_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ssbc_pkg::S_TDATA_W-1:0]   s_tdata,   // key
  input  logic                             s_tuser,   // first
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ssbc_pkg::M_TDATA_W-1:0]   m_tdata,   // bucket, slot, sorted_so_far, zero pad
  input  logic                             cfg_we,
  input  logic [ssbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ssbc_pkg::*;

  localparam int KW      = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int TALLY_W = $clog2(MAX_ITEMS + 1);
  localparam int BIDX_W  = $clog2(MAX_BUCKETS);

  localparam logic [BUCKET_COUNT_W-1:0] MAX_BUCKETS_C = BUCKET_COUNT_W'(MAX_BUCKETS);
  localparam logic [TALLY_W-1:0]        MAX_ITEMS_C   = TALLY_W'(MAX_ITEMS);

  // configuration
  logic [BUCKET_COUNT_W-1:0] bucket_count;
  logic [SPLITTER_W-1:0]     splitter [SPLITTER_REGS];

  // input stage
  logic          in_valid;
  logic [KW-1:0] in_key;
  logic          in_first;

  // state
  logic [TALLY_W-1:0] tally      [MAX_BUCKETS];
  logic [TALLY_W-1:0] tally_next [MAX_BUCKETS];
  logic [KW-1:0]      previous_key;
  logic               still_sorted;
  logic               still_sorted_next;
  logic               have_previous;

  // result stage
  logic                out_valid;
  logic [BUCKET_W-1:0] out_bucket;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_sorted;

  logic                      advance;
  logic [BUCKET_COUNT_W-1:0] n_clip;
  logic [BUCKET_W-1:0]       n_active;
  logic [BUCKET_W-1:0]       bucket_sum;
  logic [BUCKET_W-1:0]       bucket_sel;
  logic [BIDX_W-1:0]         bucket_idx;
  logic [TALLY_W-1:0]        slot_cur;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_sorted, out_slot, out_bucket});

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
      for (int i = 0; i < SPLITTER_REGS; i++) begin
        splitter[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_BUCKET_COUNT) begin
        bucket_count <= cfg_data[BUCKET_COUNT_W-1:0];
      end
      for (int i = 0; i < SPLITTER_REGS; i++) begin
        if (cfg_index == REG_SPLITTER_0 + CFG_INDEX_W'(i) && cfg_index <= REG_SPLITTER_6) begin
          splitter[i] <= cfg_data[SPLITTER_W-1:0];
        end
      end
    end
  end

  // active splitter count
  always_comb begin
    n_clip = bucket_count;
    if (n_clip > MAX_BUCKETS_C) begin
      n_clip = MAX_BUCKETS_C;
    end
    if (n_clip == '0) begin
      n_clip = BUCKET_COUNT_W'(1);
    end
    n_clip = n_clip - BUCKET_COUNT_W'(1);
    if (n_clip > BUCKET_COUNT_W'(SPLITTER_REGS)) begin
      n_clip = BUCKET_COUNT_W'(SPLITTER_REGS);
    end
    n_active = n_clip[BUCKET_W-1:0];
  end

  // bucket: splitters at or below the key
  always_comb begin
    bucket_sum = '0;
    for (int i = 0; i < SPLITTER_REGS; i++) begin
      if (BUCKET_W'(i) < n_active && splitter[i][KW-1:0] <= in_key) begin
        bucket_sum = bucket_sum + BUCKET_W'(1);
      end
    end
    bucket_sel = bucket_sum;
    if ({1'b0, bucket_sum} >= (BUCKET_W + 1)'(MAX_BUCKETS)) begin
      bucket_sel = BUCKET_W'(MAX_BUCKETS - 1);
    end
    bucket_idx = bucket_sel[BIDX_W-1:0];
  end

  // tally and sorted update
  always_comb begin
    for (int j = 0; j < MAX_BUCKETS; j++) begin
      tally_next[j] = in_first ? '0 : tally[j];
    end
    slot_cur = tally_next[bucket_idx];
    if (slot_cur < MAX_ITEMS_C) begin
      tally_next[bucket_idx] = slot_cur + TALLY_W'(1);
    end
    still_sorted_next = in_first ? 1'b1 : still_sorted;
    if (!in_first && have_previous && in_key < previous_key) begin
      still_sorted_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      previous_key  <= '0;
      still_sorted  <= 1'b1;
      have_previous <= 1'b0;
      for (int j = 0; j < MAX_BUCKETS; j++) begin
        tally[j] <= '0;
      end
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid     <= 1'b1;
        previous_key  <= in_key;
        still_sorted  <= still_sorted_next;
        have_previous <= 1'b1;
        for (int j = 0; j < MAX_BUCKETS; j++) begin
          tally[j] <= tally_next[j];
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_key   <= s_tdata[KW-1:0];
      in_first <= s_tuser;
    end
    if (advance) begin
      out_bucket <= bucket_sel;
      out_slot   <= SLOT_W'(slot_cur);
      out_sorted <= still_sorted_next;
    end
  end

endmodule

### sv/ssbc_checker.sv
`timescale 1ns / 1ps
// port-level checks for the samplesort bucket classifier, bound to the top level
// depends on ssbc_pkg and sample_sort_bucket_classifier
module ssbc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ssbc_pkg::M_TDATA_W-1:0] m_tdata
);
  import ssbc_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // draining output always frees the input side
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // reset empties the result stage
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // no result rises straight out of reset
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(rst))
    else $error("result appeared straight out of reset");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:RESULT_W] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind sample_sort_bucket_classifier ssbc_checker u_ssbc_checker (.*);

### dv/sample_sort_bucket_classifier_tb.sv
`timescale 1ns / 1ps
// self-checking bench for sample_sort_bucket_classifier: directed, random, backpressure
// and full-rate tests against a built-in bucket predictor
// depends on ssbc_pkg and sample_sort_bucket_classifier
module sample_sort_bucket_classifier_tb;
  import ssbc_pkg::*;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [SLOT_W-1:0]   slot;
    logic                sorted_so_far;
  } bucket_result_t;

  localparam int HOLD_CYCLES = 300;
  localparam int SPL_IDX_W   = $clog2(SPLITTER_REGS);

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;   // key
  logic                   s_tuser   = 1'b0; // first
  logic                   m_tready  = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  wire                    s_tready;
  wire                    m_tvalid;
  wire  [M_TDATA_W-1:0]   m_tdata;  // bucket, slot, sorted_so_far, zero pad

  // predictor copy of registers and state
  logic [BUCKET_COUNT_W-1:0] bucket_count_q;
  logic [SPLITTER_W-1:0]     splitter_q [SPLITTER_REGS];
  logic [SLOT_W-1:0]         tally_q [MAX_BUCKETS_DEF];
  logic [KEY_FIELD_W-1:0]    last_key_q;
  logic                      still_sorted_q;
  logic                      seen_key_q;

  bucket_result_t pending_results [$];

  bit idle_on  = 1'b0;
  bit stall_on = 1'b0;
  int hold_request = 0;
  int hold_count   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int errors       = 0;

  sample_sort_bucket_classifier uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results pending", pending_results.size());
    $display("sample_sort_bucket_classifier: mismatch");
    $finish;
  end

  function automatic bucket_result_t classify_key(input logic [KEY_FIELD_W-1:0] key,
                                                  input logic first);
    bucket_result_t r;
    int n;
    int bkt;
    int i;
    if (first) begin
      for (i = 0; i < MAX_BUCKETS_DEF; i++) tally_q[i] = '0;
      still_sorted_q = 1'b1;
      seen_key_q = 1'b0;
    end
    n = int'(bucket_count_q);
    if (n > MAX_BUCKETS_DEF) n = MAX_BUCKETS_DEF;
    if (n < 1) n = 1;
    n = n - 1;
    bkt = 0;
    for (i = 0; i < n; i++) begin
      if (splitter_q[i] <= key) bkt++;
    end
    if (bkt >= MAX_BUCKETS_DEF) bkt = MAX_BUCKETS_DEF - 1;
    r.bucket = bkt[BUCKET_W-1:0];
    r.slot = tally_q[bkt];
    if (tally_q[bkt] < MAX_ITEMS_DEF) tally_q[bkt] = tally_q[bkt] + 1'b1;
    if (seen_key_q && key < last_key_q) still_sorted_q = 1'b0;
    last_key_q = key;
    seen_key_q = 1'b1;
    r.sorted_so_far = still_sorted_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("error at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == REG_BUCKET_COUNT)
      bucket_count_q = value[BUCKET_COUNT_W-1:0];
    else if (idx >= REG_SPLITTER_0 && idx <= REG_SPLITTER_6)
      splitter_q[SPL_IDX_W'(idx - REG_SPLITTER_0)] = value;
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_key(input logic [KEY_FIELD_W-1:0] key, input logic first);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(classify_key(key, first));
    items_sent++;
  endtask

  // block idle: every request answered
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // output side: random stalls, long hold on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        m_tready <= 1'b0;
        hold_count = 0;
        while (hold_count < hold_request) begin
          @(posedge clk);
          hold_count++;
        end
        hold_request = 0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_result
    bucket_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(m_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[BUCKET_W-1:0] !== want.bucket)
          report_mismatch("bucket", 32'(m_tdata[BUCKET_W-1:0]), 32'(want.bucket));
        if (m_tdata[BUCKET_W +: SLOT_W] !== want.slot)
          report_mismatch("slot", 32'(m_tdata[BUCKET_W +: SLOT_W]), 32'(want.slot));
        if (m_tdata[BUCKET_W + SLOT_W] !== want.sorted_so_far)
          report_mismatch("sorted_so_far", 32'(m_tdata[BUCKET_W + SLOT_W]),
                          32'(want.sorted_so_far));
      end
    end
  end

  function automatic logic [KEY_FIELD_W-1:0] noisy_key(input bit narrow);
    logic [SPLITTER_W-1:0] pick;
    pick = splitter_q[$urandom_range(0, SPLITTER_REGS - 1)];
    case ($urandom_range(0, 3))
      0:       return narrow ? $urandom_range(0, 70) : $urandom();
      1:       return pick;
      2:       return pick - 1'b1;
      default: return pick + 1'b1;
    endcase
  endfunction

  task automatic program_random_config(output bit narrow);
    logic [SPLITTER_W-1:0]     vals [SPLITTER_REGS];
    logic [SPLITTER_W-1:0]     tmp;
    logic [BUCKET_COUNT_W-1:0] count;
    int i;
    int j;
    narrow = $urandom_range(0, 2) == 0;
    for (i = 0; i < SPLITTER_REGS; i++) vals[i] = narrow ? $urandom_range(0, 63) : $urandom();
    if ($urandom_range(0, 3) != 0) begin
      for (i = 1; i < SPLITTER_REGS; i++) begin
        tmp = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > tmp) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = tmp;
      end
    end
    count = BUCKET_COUNT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(2, 8));
    write_reg(REG_BUCKET_COUNT, CFG_DATA_W'(count));
    for (i = 0; i < SPLITTER_REGS; i++) write_reg(CFG_INDEX_W'(REG_SPLITTER_0 + i), vals[i]);
  endtask

  task automatic test_reset_defaults();
    // eight buckets, all splitters zero: every key lands in the top bucket
    send_key(32'h0000_0000, 1'b1);
    send_key(32'h0000_0001, 1'b0);
    send_key(32'hFFFF_FFFF, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    drain();
  endtask

  task automatic test_directed_boundaries();
    int i;
    write_reg(REG_BUCKET_COUNT, 8);
    write_reg(REG_SPLITTER_0, 32'h0000_0000);
    for (i = 1; i < SPLITTER_REGS - 1; i++)
      write_reg(CFG_INDEX_W'(REG_SPLITTER_0 + i), 32'h10 * (i + 1));
    write_reg(REG_SPLITTER_6, 32'hFFFF_FFFF);
    send_key(32'h0000_0000, 1'b1);
    send_key(32'h0000_001F, 1'b0);
    send_key(32'h0000_0020, 1'b0);
    send_key(32'h0000_005F, 1'b0);
    send_key(32'h0000_0060, 1'b0);
    send_key(32'hFFFF_FFFE, 1'b0);
    send_key(32'hFFFF_FFFF, 1'b0);
    send_key(32'h0000_0040, 1'b0);
    send_key(32'h5555_5555, 1'b0);
    send_key(32'hAAAA_AAAA, 1'b0);
    send_key(32'h0000_0030, 1'b1);
    send_key(32'h0000_0030, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    drain();
  endtask

  task automatic test_bucket_count_extremes();
    logic [BUCKET_COUNT_W-1:0] counts [6];
    int i;
    counts = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd15};
    for (i = 0; i < SPLITTER_REGS; i++)
      write_reg(CFG_INDEX_W'(REG_SPLITTER_0 + i), 100 * (i + 1));
    for (i = 0; i < 6; i++) begin
      write_reg(REG_BUCKET_COUNT, CFG_DATA_W'(counts[i]));
      send_key(32'd100, 1'b1);
      send_key(32'hFFFF_FFFF, 1'b0);
      send_key(32'd0, 1'b0);
      send_key(32'd200, 1'b0);
      drain();
    end
  endtask

  task automatic test_ignored_indexes();
    int idx;
    int i;
    for (idx = REG_SPLITTER_6 + 1; idx < (1 << CFG_INDEX_W); idx++)
      write_reg(CFG_INDEX_W'(idx), $urandom());
    for (i = 0; i < 8; i++) send_key($urandom_range(0, 900), i == 0);
    drain();
  endtask

  task automatic test_unsorted_splitters();
    int i;
    write_reg(REG_BUCKET_COUNT, 8);
    for (i = 0; i < SPLITTER_REGS; i++)
      write_reg(CFG_INDEX_W'(REG_SPLITTER_0 + i), $urandom_range(0, 15));
    for (i = 0; i < 20; i++) send_key($urandom_range(0, 16), i == 0);
    drain();
  endtask

  task automatic test_random_sets(input int n_items);
    logic [KEY_FIELD_W-1:0] run_key;
    int sent_here;
    int phase_items;
    int set_len;
    int phase;
    int j;
    bit narrow;
    bit tidy;
    sent_here = 0;
    phase = 0;
    while (sent_here < n_items) begin
      drain();
      idle_on  = (phase % 3) != 2;
      stall_on = idle_on;
      program_random_config(narrow);
      phase_items = 0;
      while (phase_items < 150 && sent_here < n_items) begin
        set_len = $urandom_range(1, 40);
        tidy = $urandom_range(0, 4) != 0;
        run_key = narrow ? $urandom_range(0, 20) : $urandom_range(0, 32'h3FFF_FFFF);
        for (j = 0; j < set_len; j++) begin
          if (!tidy)
            run_key = noisy_key(narrow);
          else if (j > 0 && narrow)
            run_key = run_key + $urandom_range(0, 3);
          else if (j > 0)
            run_key = run_key + ($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 1 << 24));
          send_key(run_key, j == 0 && $urandom_range(0, 5) != 0);
          phase_items++;
          sent_here++;
        end
      end
      phase++;
    end
    drain();
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_backpressure();
    int i;
    idle_on = 1'b0;
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 40; i++) send_key($urandom(), i == 0);
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_full_rate();
    int i;
    idle_on  = 1'b0;
    stall_on = 1'b0;
    write_reg(REG_BUCKET_COUNT, 4);
    write_reg(REG_SPLITTER_0, 32'h0000_1000);
    write_reg(CFG_INDEX_W'(REG_SPLITTER_0 + 1), 32'h0000_2000);
    write_reg(CFG_INDEX_W'(REG_SPLITTER_0 + 2), 32'h0000_3000);
    for (i = 0; i < 100; i++) send_key(KEY_FIELD_W'(i * 97), i == 0 || i == 60);
    drain();
  endtask

  initial begin
    int wait_cycles;
    bucket_count_q = BUCKET_COUNT_RESET;
    for (int i = 0; i < SPLITTER_REGS; i++) splitter_q[i] = '0;
    for (int i = 0; i < MAX_BUCKETS_DEF; i++) tally_q[i] = '0;
    last_key_q = '0;
    still_sorted_q = 1'b1;
    seen_key_q = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on  = 1'b1;
    stall_on = 1'b1;

    test_reset_defaults();
    test_directed_boundaries();
    test_bucket_count_extremes();
    test_ignored_indexes();
    test_unsorted_splitters();
    test_random_sets(1200);
    test_backpressure();
    test_random_sets(200);
    test_full_rate();

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("requests left without a result", pending_results.size(), 0);

    $display("covered %0d requests and %0d results over %0d register writes", items_sent,
             results_seen, reg_writes);
    $display("bucket counts 0 to 15, ignored indexes, a %0d-cycle output hold, full-rate run",
             HOLD_CYCLES);
    if (errors == 0)
      $display("sample_sort_bucket_classifier: match");
    else
      $display("sample_sort_bucket_classifier: mismatch");
    $finish;
  end

endmodule
